// ===== design/swm_pkg.sv =====
// Shared constants of the sliding window maximum filter.
package swm_pkg;

  // Default number of cells, which is the largest window the filter supports.
  localparam int unsigned WINDOW_MAX_DEF = 64;

  // Default sample width in bits.
  localparam int unsigned SAMPLE_WIDTH_DEF = 16;

  // Width of the window size register.
  localparam int unsigned CFG_WIDTH = 7;

  // Window size after reset.
  localparam logic [CFG_WIDTH-1:0] WINDOW_SIZE_RESET = CFG_WIDTH'(1);

endpackage

// ===== design/swm_if.sv =====
// Stream interfaces of the sliding window maximum filter: samples, results and configuration.

interface swm_sample_if #(
  parameter int unsigned SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           start_of_sequence;

  modport source (output valid, output sample, output start_of_sequence, input ready);
  modport sink (input valid, input sample, input start_of_sequence, output ready);
endinterface

interface swm_result_if #(
  parameter int unsigned SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] window_max;

  modport source (output valid, output window_max, input ready);
  modport sink (input valid, input window_max, output ready);
endinterface

interface swm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [swm_pkg::CFG_WIDTH-1:0]    window_size;

  modport source (output valid, output window_size, input ready);
  modport sink (input valid, input window_size, output ready);
endinterface

// ===== design/sliding_window_maximum_core.sv =====
// Top level of the sliding window maximum filter: cell chain, control and maximum tree.
//
// Usage: samples arrive on the samples channel, one transfer per item, with a
// start_of_sequence flag that clears all candidates before the sample is taken.
// Once window_size samples of the current sequence have arrived, each sample
// yields one transfer on the results channel carrying the maximum of the last
// window_size samples; earlier samples yield nothing.
// The cfg channel writes window_size (0 acts as 1, values above WINDOW_MAX act as
// WINDOW_MAX); it is always ready and is meant to be written while the filter is idle.
// Throughput: one sample per clock cycle while results are not stalled. Every cell
// compares its held sample against the new one in the same cycle and hands its
// candidate to the next cell. The cells load a sample at its transfer edge; its
// result then passes through the registered levels of the maximum tree to the
// root register, where it is offered.
// When the results receiver stalls, the whole pipeline holds and samples.ready
// drops; the output register keeps its value until it is taken.
// Reset clears all candidates, the sample count and the pipeline, and sets
// window_size to 1.
module sliding_window_maximum_core #(
  parameter int unsigned WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
  parameter int unsigned SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  swm_cfg_if.sink       cfg,
  swm_sample_if.sink    samples,
  swm_result_if.source  results
);

  localparam int unsigned CW = swm_pkg::CFG_WIDTH;
  localparam int unsigned WW = $clog2(WINDOW_MAX + 1);
  localparam int unsigned KW = (CW > WW) ? CW : WW;

  logic [CW-1:0]                 window_size;
  logic [KW-1:0]                 k;
  logic [KW-1:0]                 seen_count;
  logic [KW-1:0]                 seen_count_next;
  logic [KW-1:0]                 seen_base;
  logic                          emit;
  logic                          stage_valid;
  logic                          advance;
  logic                          accept;
  logic                          tree_valid;
  logic signed [SAMPLE_WIDTH-1:0] tree_max;

  logic                          cell_alive [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] cell_value [WINDOW_MAX];
  logic                          hand_alive [WINDOW_MAX-1];
  logic signed [SAMPLE_WIDTH-1:0] hand_value [WINDOW_MAX-1];

  // Configuration register, written on every cfg transfer.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= swm_pkg::WINDOW_SIZE_RESET;
    end else if (cfg.valid) begin
      window_size <= cfg.window_size;
    end
  end

  // Effective window length.
  always_comb begin
    if (window_size == '0) begin
      k = KW'(1);
    end else if (KW'(window_size) > KW'(WINDOW_MAX)) begin
      k = KW'(WINDOW_MAX);
    end else begin
      k = KW'(window_size);
    end
  end

  // The pipeline moves whenever the output register is free or being taken.
  assign advance       = !results.valid || results.ready;
  assign samples.ready = advance;
  assign accept        = samples.valid && advance;

  // Sample count of the current sequence, saturating at the window length.
  always_comb begin
    seen_base = samples.start_of_sequence ? '0 : seen_count;
    if (seen_base > k) begin
      seen_base = k;
    end
    if (seen_base < k) begin
      seen_count_next = seen_base + KW'(1);
    end else begin
      seen_count_next = seen_base;
    end
    emit = (seen_count_next >= k);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_count  <= '0;
      stage_valid <= 1'b0;
    end else if (advance) begin
      stage_valid <= accept && emit;
      if (accept) begin
        seen_count <= seen_count_next;
      end
    end
  end

  // Chain of cells; cell i holds the sample of age i + 1 once a new one arrives.
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic                           prev_alive;
    logic signed [SAMPLE_WIDTH-1:0] prev_value;

    if (i == 0) begin : g_head
      assign prev_alive = 1'b1;
      assign prev_value = samples.sample;
    end else begin : g_body
      assign prev_alive = hand_alive[i-1];
      assign prev_value = hand_value[i-1];
    end

    if (i < WINDOW_MAX - 1) begin : g_mid
      swm_cell #(
        .INDEX (i),
        .SW    (SAMPLE_WIDTH),
        .KW    (KW)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .en         (accept),
        .start      (samples.start_of_sequence),
        .k          (k),
        .sample     (samples.sample),
        .prev_alive (prev_alive),
        .prev_value (prev_value),
        .alive      (cell_alive[i]),
        .value      (cell_value[i]),
        .hand_alive (hand_alive[i]),
        .hand_value (hand_value[i])
      );
    end else begin : g_tail
      swm_cell #(
        .INDEX (i),
        .SW    (SAMPLE_WIDTH),
        .KW    (KW)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .en         (accept),
        .start      (samples.start_of_sequence),
        .k          (k),
        .sample     (samples.sample),
        .prev_alive (prev_alive),
        .prev_value (prev_value),
        .alive      (cell_alive[i]),
        .value      (cell_value[i]),
        .hand_alive (),
        .hand_value ()
      );
    end
  end

  // Maximum over the surviving candidates.
  swm_max_tree #(
    .N_CELLS (WINDOW_MAX),
    .SW      (SAMPLE_WIDTH)
  ) u_tree (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .in_valid   (stage_valid),
    .cell_value (cell_value),
    .cell_alive (cell_alive),
    .out_valid  (tree_valid),
    .out_max    (tree_max)
  );

  assign results.valid      = tree_valid;
  assign results.window_max = tree_max;

endmodule

// ===== design/swm_cell.sv =====
// One cell of the candidate chain: holds a sample of fixed age and its candidate flag.
module swm_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned SW    = swm_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned KW    = swm_pkg::CFG_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 start,
  input  logic [KW-1:0]        k,
  input  logic signed [SW-1:0] sample,
  input  logic                 prev_alive,
  input  logic signed [SW-1:0] prev_value,
  output logic                 alive,
  output logic signed [SW-1:0] value,
  output logic                 hand_alive,
  output logic signed [SW-1:0] hand_value
);

  // Age of the held sample at the moment the next sample arrives.
  localparam int unsigned AGE = INDEX + 1;

  logic expire;
  logic beaten;

  // A candidate leaves when it ages out of the window, when a new sequence
  // starts, or when the new sample is at least as large.
  always_comb begin
    expire     = (32'(k) <= AGE);
    beaten     = (value <= sample);
    hand_alive = alive && !start && !expire && !beaten;
    hand_value = value;
  end

  // Candidate flag, shifted in from the younger neighbor.
  always_ff @(posedge clk) begin
    if (rst) begin
      alive <= 1'b0;
    end else if (en) begin
      alive <= prev_alive;
    end
  end

  // Sample value, shifted in from the younger neighbor.
  always_ff @(posedge clk) begin
    if (en) begin
      value <= prev_value;
    end
  end

endmodule

// ===== design/swm_max_tree.sv =====
// Registered maximum tree over the candidate cells, one tree level per pipeline stage.
module swm_max_tree #(
  parameter int unsigned N_CELLS = swm_pkg::WINDOW_MAX_DEF,
  parameter int unsigned SW      = swm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 in_valid,
  input  logic signed [SW-1:0] cell_value [N_CELLS],
  input  logic                 cell_alive [N_CELLS],
  output logic                 out_valid,
  output logic signed [SW-1:0] out_max
);

  localparam int unsigned LV = $clog2(N_CELLS);
  localparam int unsigned NL = 1 << LV;

  // Node registers in heap order, root at 1.
  logic signed [SW-1:0] nv  [1:NL-1];
  logic                 nok [1:NL-1];
  // All nodes and leaves in heap order, leaves at NL and up.
  logic signed [SW-1:0] av  [1:2*NL-1];
  logic                 aok [1:2*NL-1];
  // Stage valid flags, one per tree level.
  logic                 vld [1:LV];

  // Gather the node registers and the leaves; padding leaves hold no candidate.
  always_comb begin
    for (int h = 1; h < NL; h++) begin
      av[h]  = nv[h];
      aok[h] = nok[h];
    end
    for (int i = 0; i < NL; i++) begin
      if (i < N_CELLS) begin
        av[NL+i]  = cell_value[i];
        aok[NL+i] = cell_alive[i];
      end else begin
        av[NL+i]  = '0;
        aok[NL+i] = 1'b0;
      end
    end
  end

  // Each node keeps the larger of its two children that holds a candidate.
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int h = 1; h < NL; h++) begin
        nok[h] <= aok[2*h] || aok[2*h+1];
        if (aok[2*h] && (!aok[2*h+1] || (av[2*h] >= av[2*h+1]))) begin
          nv[h] <= av[2*h];
        end else begin
          nv[h] <= av[2*h+1];
        end
      end
    end
  end

  // Valid flags travel with the tree levels.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= LV; s++) begin
        vld[s] <= 1'b0;
      end
    end else if (advance) begin
      vld[1] <= in_valid;
      for (int s = 2; s <= LV; s++) begin
        vld[s] <= vld[s-1];
      end
    end
  end

  assign out_valid = vld[LV];
  assign out_max   = nv[1];

endmodule

// ===== test/tb_sliding_window_maximum_core.sv =====
// Self-checking testbench for the sliding window maximum filter core.
`timescale 1ns / 100ps

module tb_sliding_window_maximum_core;

  localparam int SW = swm_pkg::SAMPLE_WIDTH_DEF;
  localparam int WMAX = swm_pkg::WINDOW_MAX_DEF;
  localparam int CW = swm_pkg::CFG_WIDTH;
  localparam int PW = $clog2(2 * WMAX);
  // Cycles to let the filter settle after the last result before a window write.
  localparam int SETTLE_CYCLES = 16;
  // Length of the long result stall that backs the filter up into its input.
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int NUM_DIRECTED = 29;
  localparam int NUM_PLANNED = 10;
  localparam int NUM_PHASES = 11;

  typedef enum logic {
    ROW_SAMPLE,
    ROW_WINDOW
  } row_kind_t;

  typedef struct packed {
    row_kind_t       kind;
    logic [CW-1:0]   window;
    logic            sos;
    logic signed [SW-1:0] value;
    logic            typed;
    logic signed [SW-1:0] typed_max;
  } step_row_t;

  typedef struct {
    logic signed [SW-1:0] value;
    logic [PW-1:0]        position;
  } candidate_t;

  logic clk = 1'b0;
  logic rst;

  swm_cfg_if    cfg_bus ();
  swm_sample_if sample_bus ();
  swm_result_if result_bus ();

  sliding_window_maximum_core uut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .samples(sample_bus),
    .results(result_bus)
  );

  // Directed steps: window writes and samples. Rows with typed set carry their
  // expected maximum directly; the others are checked against the predictor.
  step_row_t directed_steps [NUM_DIRECTED] = '{
    // Window of one after reset: every sample is its own maximum.
    '{ROW_SAMPLE, 7'd0, 1'b1, 16'sh0000, 1'b1, 16'sh0000},
    '{ROW_SAMPLE, 7'd0, 1'b0, 16'sh7FFF, 1'b1, 16'sh7FFF},
    '{ROW_SAMPLE, 7'd0, 1'b0, 16'sh8000, 1'b1, 16'sh8000},
    '{ROW_SAMPLE, 7'd0, 1'b0, 16'shFFFF, 1'b1, 16'shFFFF},
    '{ROW_SAMPLE, 7'd0, 1'b0, 16'sh0001, 1'b1, 16'sh0001},
    // A window size of zero acts as one.
    '{ROW_WINDOW, 7'd0, 1'b0, 16'sh0000, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, 7'd0, 1'b0, 16'sh5555, 1'b1, 16'sh5555},
    '{ROW_SAMPLE, 7'd0, 1'b0, 16'shAAAA, 1'b1, 16'shAAAA},
    // Window of three: descending run, equal values, extremes, a restart.
    '{ROW_WINDOW, 7'd3, 1'b0, 16'sh0000, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, 7'd0, 1'b1, 16'sh0005, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, 7'd0, 1'b0, 16'sh0003, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, 7'd0, 1'b0, 16'sh0001, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, 7'd0, 1'b0, 16'sh0007, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, 7'd0, 1'b0, 16'sh0007, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, 7'd0, 1'b0, 16'sh8000, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, 7'd0, 1'b0, 16'sh8000, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, 7'd0, 1'b0, 16'sh8000, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, 7'd0, 1'b1, 16'sh7FFF, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, 7'd0, 1'b0, 16'sh0000, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, 7'd0, 1'b0, 16'shFFFB, 1'b0, 16'sh0000},
    // Window shrinks and then grows in the middle of a sequence.
    '{ROW_WINDOW, 7'd2, 1'b0, 16'sh0000, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, 7'd0, 1'b0, 16'shFFF9, 1'b0, 16'sh0000},
    '{ROW_WINDOW, 7'd5, 1'b0, 16'sh0000, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, 7'd0, 1'b0, 16'sh0002, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, 7'd0, 1'b0, 16'shFFFF, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, 7'd0, 1'b0, 16'shFFFD, 1'b0, 16'sh0000},
    // A window above the supported maximum saturates.
    '{ROW_WINDOW, 7'd127, 1'b0, 16'sh0000, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, 7'd0, 1'b1, 16'sh0064, 1'b0, 16'sh0000},
    '{ROW_SAMPLE, 7'd0, 1'b0, 16'shFF9C, 1'b0, 16'sh0000}
  };

  logic [CW-1:0] window_plan [NUM_PLANNED] = '{
    7'd1, 7'd64, 7'd127, 7'd2, 7'd0, 7'd3, 7'd65, 7'd8, 7'd16, 7'd5
  };

  // Predictor state: candidate list (oldest first), position and sample count.
  candidate_t           cand_list [$];
  logic [PW-1:0]        next_position = '0;
  int                   seen_in_window = 0;
  logic [CW-1:0]        window_reg = swm_pkg::WINDOW_SIZE_RESET;

  logic signed [SW-1:0] pending_max [$];

  int  samples_taken = 0;
  int  maxima_checked = 0;
  int  mismatch_count = 0;
  int  window_writes = 0;
  int  idle_cycles = 0;
  bit  gaps_on = 1'b0;
  int  burst_left = 0;
  int  stall_mode = 0;
  bit  hold_request = 1'b0;

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Effective window length for a register value.
  function automatic int span_of(input logic [CW-1:0] w);
    if (w == '0) begin
      return 1;
    end
    if (w > WMAX) begin
      return WMAX;
    end
    return int'(w);
  endfunction

  // Updates the candidate list with one sample and gives the window maximum,
  // if the window is full.
  function automatic void advance_window(input logic signed [SW-1:0] value, input logic sos,
                                         output bit emits,
                                         output logic signed [SW-1:0] max_out);
    int            k;
    logic [PW-1:0] age;
    candidate_t    fresh;
    k = span_of(window_reg);
    if (sos) begin
      cand_list.delete();
      next_position = '0;
      seen_in_window = 0;
    end
    // Retire candidates that have aged out of the window.
    while (cand_list.size() > 0) begin
      age = next_position - cand_list[0].position;
      if (age < k) begin
        break;
      end
      cand_list.delete(0);
    end
    // Younger candidates not above the new sample can never be the maximum.
    while (cand_list.size() > 0 && cand_list[$].value <= value) begin
      cand_list.delete(cand_list.size() - 1);
    end
    if (cand_list.size() >= WMAX) begin
      cand_list.delete(0);
    end
    fresh.value = value;
    fresh.position = next_position;
    cand_list.insert(cand_list.size(), fresh);
    next_position = next_position + 1'b1;
    if (seen_in_window > k) begin
      seen_in_window = k;
    end
    if (seen_in_window < k) begin
      seen_in_window++;
    end
    emits = (seen_in_window >= k);
    max_out = cand_list[0].value;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("MISMATCH: %s", msg);
    end
  endtask

  // Offers one sample, with an optional gap before it, and records the
  // expected maximum once the transfer happens.
  task automatic offer_sample(input logic signed [SW-1:0] value, input logic sos,
                              input logic typed, input logic signed [SW-1:0] typed_max);
    int                   gap;
    bit                   emits;
    logic signed [SW-1:0] predicted;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
      repeat (gap) begin
        @(negedge clk);
        sample_bus.valid = 1'b0;
      end
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    @(negedge clk);
    sample_bus.valid = 1'b1;
    sample_bus.sample = value;
    sample_bus.start_of_sequence = sos;
    do begin
      @(posedge clk);
    end while (!sample_bus.ready);
    samples_taken++;
    advance_window(value, sos, emits, predicted);
    if (typed) begin
      pending_max.insert(pending_max.size(), typed_max);
    end else if (emits) begin
      pending_max.insert(pending_max.size(), predicted);
    end
  endtask

  // Stops offering samples and waits until the filter has gone quiet.
  task automatic wait_idle();
    @(negedge clk);
    sample_bus.valid = 1'b0;
    while (pending_max.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [CW-1:0] w);
    @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.window_size = w;
    do begin
      @(posedge clk);
    end while (!cfg_bus.ready);
    window_reg = w;
    window_writes++;
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // Result receiver: its own stall pattern, plus one long hold-off on request.
  initial begin
    int hold_left;
    int rx_tick;
    hold_left = 0;
    rx_tick = 0;
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_tick++;
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready = 1'b0;
      end else begin
        case (stall_mode)
          0: result_bus.ready = 1'b1;
          1: result_bus.ready = ($urandom_range(0, 3) != 0);
          default: result_bus.ready = ((rx_tick % 9) < 6);
        endcase
      end
    end
  end

  // Result checking and the watchdog on stalled transfers.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_bus.valid && result_bus.ready) begin
        if (pending_max.size() == 0) begin
          report_mismatch($sformatf("unexpected window_max %0d", result_bus.window_max));
        end else begin
          if (result_bus.window_max !== pending_max[0]) begin
            report_mismatch($sformatf("window_max expected %0d, got %0d",
                                      pending_max[0], result_bus.window_max));
          end
          pending_max.delete(0);
          maxima_checked++;
        end
      end
      if ((result_bus.valid && result_bus.ready) || (sample_bus.valid && sample_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
          $display("tb_sliding_window_maximum_core failed");
          $finish;
        end
      end
    end
  end

  // Stimulus: directed steps, then random phases over several window sizes.
  initial begin
    logic [CW-1:0]        w;
    logic signed [SW-1:0] base;
    logic signed [SW-1:0] stride;
    logic signed [SW-1:0] v;
    int                   k;
    int                   quota;
    int                   sent;
    int                   seq_len;
    int                   style;
    logic                 sos;
    sample_bus.valid = 1'b0;
    sample_bus.sample = '0;
    sample_bus.start_of_sequence = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.window_size = '0;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    gaps_on = 1'b1;
    stall_mode = 1;
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (directed_steps[i].kind == ROW_WINDOW) begin
        wait_idle();
        write_window(directed_steps[i].window);
      end else begin
        offer_sample(directed_steps[i].value, directed_steps[i].sos,
                     directed_steps[i].typed, directed_steps[i].typed_max);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      w = (p < NUM_PLANNED) ? window_plan[p] : CW'($urandom_range(0, 127));
      k = span_of(w);
      quota = (k >= 32) ? 150 : 40;
      wait_idle();
      write_window(w);
      gaps_on = ($urandom_range(0, 3) != 0);
      stall_mode = $urandom_range(0, 2);
      // One phase runs with no idling on either side.
      if (p == 3) begin
        gaps_on = 1'b0;
        stall_mode = 0;
      end
      // With the largest window, back the filter up with a long result stall.
      if (p == 1) begin
        hold_request = 1'b1;
      end
      sent = 0;
      while (sent < quota) begin
        // Mostly whole sequences that fill the window; some are cut short, and
        // some continue the previous sequence without a start flag.
        sos = ($urandom_range(0, 4) != 0);
        seq_len = ($urandom_range(0, 4) != 0) ? $urandom_range(k, k + 24) :
                  $urandom_range(1, k);
        style = $urandom_range(0, 4);
        base = SW'($urandom);
        stride = SW'($urandom_range(0, 300));
        for (int j = 0; j < seq_len && sent < quota; j++) begin
          case (style)
            0: v = SW'($urandom);
            1: v = base + stride * SW'(j);
            2: v = base - stride * SW'(j);
            3: v = SW'($urandom_range(0, 4)) - 16'sd2;
            default: begin
              case ($urandom_range(0, 3))
                0: v = 16'sh7FFF;
                1: v = 16'sh8000;
                2: v = 16'sh0000;
                default: v = 16'shFFFF;
              endcase
            end
          endcase
          offer_sample(v, (j == 0) ? sos : ($urandom_range(0, 49) == 0), 1'b0, '0);
          sent++;
        end
      end
    end

    wait_idle();
    if (pending_max.size() != 0) begin
      report_mismatch($sformatf("%0d window maxima never arrived", pending_max.size()));
    end
    $display("Run covered %0d samples over %0d window writes, sizes 0, 1, 64 and 127 included,",
             samples_taken, window_writes);
    $display("with a long result stall; %0d window maxima compared, %0d mismatches.",
             maxima_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_sliding_window_maximum_core passed");
    end else begin
      $display("tb_sliding_window_maximum_core failed");
    end
    $finish;
  end

endmodule

// ===== sliding_window_maximum_core.f =====
design/swm_pkg.sv
design/swm_if.sv
design/swm_cell.sv
design/swm_max_tree.sv
design/sliding_window_maximum_core.sv
test/tb_sliding_window_maximum_core.sv
